[src/circle_overlap_area_top_assert.svh]
// assertion macros for the circle overlap area block
// expects i_clk and i_rst_n in the scope of each use
`ifndef CIRCLE_OVERLAP_AREA_TOP_ASSERT_SVH
`define CIRCLE_OVERLAP_AREA_TOP_ASSERT_SVH

// same-cycle implication
`define COA_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("coa assertion failed");

// next-cycle implication
`define COA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("coa assertion failed");

`endif

[src/coa_pkg.sv]
// shared widths, stage numbers, constants and helpers for the circle overlap area block
// no dependencies
`timescale 1ns / 1ps

package coa_pkg;

    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 8;
    localparam int AREA_W    = 2 * COORD_W - FRAC_BITS + 2;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int SUM_W     = COORD_W + 1;
    localparam int PQ_W      = 2 * SUM_W;
    localparam int NUM_W     = SQ_W + 3;
    localparam int DIV_W     = SQ_W + 2;
    localparam int Q_BITS    = 30;
    localparam int X_W       = Q_BITS + 1;
    localparam int DIV_STEPS = Q_BITS;
    localparam int DIV_STAGES = DIV_STEPS + 1;
    localparam int SQRT_PAD  = 14;
    localparam int RAD_W     = 62;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 4;
    localparam int ISQRT_STEPS = ROOT_W;
    localparam int HP_W      = 34;
    localparam int PD_W      = 33;
    localparam int ACOS_W    = 32;
    localparam int PROD_W    = 64;
    localparam int H_W       = 2 * ROOT_W - (2 * SQRT_PAD + 1);
    localparam int TERM_W    = PROD_W - Q_BITS;
    localparam int SUMT_W    = TERM_W + 1;
    localparam int POLY_TERMS = 8;
    localparam int HORNER_STAGES = 2 * (POLY_TERMS - 1);
    localparam int PD_DELAY  = ISQRT_STEPS + 1 - HORNER_STAGES;
    localparam int ACOS_STAGES = ISQRT_STEPS + 3;

    // global stage numbers
    localparam int ST_IN       = 0;
    localparam int ST_MUL      = 1;
    localparam int ST_PREP     = 2;
    localparam int ST_CLAMP    = 3;
    localparam int ST_ROOT0    = ST_CLAMP;
    localparam int ST_DIV0     = ST_CLAMP + 1;
    localparam int ST_X        = ST_DIV0 + DIV_STAGES - 1;
    localparam int ST_ACOS0    = ST_X + 1;
    localparam int ST_ACOS_END = ST_ACOS0 + ACOS_STAGES - 1;
    localparam int ST_TERM     = ST_ACOS_END + 1;
    localparam int ST_SUM      = ST_TERM + 1;
    localparam int ST_SUB      = ST_SUM + 1;
    localparam int ST_OUT      = ST_SUB + 1;
    localparam int NUM_STAGES  = ST_OUT + 1;

    localparam logic [ACOS_W-1:0] PI_Q30  = 32'd3373259426;
    localparam logic [X_W-1:0]    Q30_ONE = X_W'(1) << Q_BITS;

    localparam logic [SUMT_W:0] ROUND_HALF = (SUMT_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [SUMT_W:0] AREA_MAX   = (SUMT_W + 1)'((65'd1 << AREA_W) - 65'd1);

    typedef enum logic [1:0] {
        CASE_DISJOINT = 2'd0,
        CASE_INSIDE   = 2'd1,
        CASE_LENS     = 2'd2
    } t_case;

    function automatic logic signed [HP_W-1:0] acos_coef(input logic [2:0] idx);
        logic signed [HP_W-1:0] c;
        case (idx)
            3'd0:    c = 34'sd1686629690;
            3'd1:    c = -34'sd230423709;
            3'd2:    c = 34'sd95540460;
            3'd3:    c = -34'sd53874249;
            3'd4:    c = 34'sd33169905;
            3'd5:    c = -34'sd18348235;
            3'd6:    c = 34'sd7161955;
            default: c = -34'sd1355589;
        endcase
        return c;
    endfunction

    // round half up to FRAC_BITS fraction bits, saturate to the area width
    function automatic logic [AREA_W-1:0] round_sat(input logic [SUMT_W-1:0] v);
        logic [SUMT_W:0] t;
        t = ({1'b0, v} + ROUND_HALF) >> FRAC_BITS;
        if (t > AREA_MAX) begin
            return '1;
        end
        return t[AREA_W-1:0];
    endfunction

endpackage

[src/coa_div.sv]
// pipelined restoring divider, one quotient bit per stage, Q30 ratio clamped to one
// depends on coa_pkg
`timescale 1ns / 1ps

module coa_div import coa_pkg::*; (
    input  logic                  i_clk,
    input  logic [DIV_STAGES-1:0] i_en,
    input  logic [DIV_W-1:0]      i_mag,
    input  logic [DIV_W-1:0]      i_den,
    input  logic                  i_clamp,
    output logic [X_W-1:0]        o_x
);

    logic [DIV_W-1:0]     r_rem   [DIV_STEPS-1];
    logic [DIV_W-1:0]     r_den   [DIV_STEPS-1];
    logic [DIV_STEPS-1:0] r_q     [DIV_STEPS];
    logic                 r_clamp [DIV_STEPS];
    logic [X_W-1:0]       r_x;

    logic [DIV_W-1:0]     c_rem_in   [DIV_STEPS];
    logic [DIV_W-1:0]     c_den_in   [DIV_STEPS];
    logic [DIV_STEPS-1:0] c_q_in     [DIV_STEPS];
    logic                 c_clamp_in [DIV_STEPS];
    logic [DIV_W-1:0]     c_shift    [DIV_STEPS];
    logic [DIV_W-1:0]     n_rem      [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_q        [DIV_STEPS];

    always_comb begin
        c_rem_in[0]   = i_mag;
        c_den_in[0]   = i_den;
        c_q_in[0]     = '0;
        c_clamp_in[0] = i_clamp;
        for (int j = 1; j < DIV_STEPS; j++) begin
            c_rem_in[j]   = r_rem[j-1];
            c_den_in[j]   = r_den[j-1];
            c_q_in[j]     = r_q[j-1];
            c_clamp_in[j] = r_clamp[j-1];
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            c_shift[j] = {c_rem_in[j][DIV_W-2:0], 1'b0};
            if (c_shift[j] >= c_den_in[j]) begin
                n_rem[j] = c_shift[j] - c_den_in[j];
                n_q[j]   = {c_q_in[j][DIV_STEPS-2:0], 1'b1};
            end else begin
                n_rem[j] = c_shift[j];
                n_q[j]   = {c_q_in[j][DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DIV_STEPS - 1; j++) begin
            if (i_en[j]) begin
                r_rem[j] <= n_rem[j];
                r_den[j] <= c_den_in[j];
            end
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (i_en[j]) begin
                r_q[j]     <= n_q[j];
                r_clamp[j] <= c_clamp_in[j];
            end
        end
        if (i_en[DIV_STEPS]) begin
            r_x <= r_clamp[DIV_STEPS-1] ? Q30_ONE : {1'b0, r_q[DIV_STEPS-1]};
        end
    end

    assign o_x = r_x;

endmodule

[src/coa_isqrt.sv]
// pipelined integer square root, two radicand bits per stage
// depends on coa_pkg
`timescale 1ns / 1ps

module coa_isqrt import coa_pkg::*; (
    input  logic                   i_clk,
    input  logic [ISQRT_STEPS-1:0] i_en,
    input  logic [RAD_W-1:0]       i_rad,
    output logic [ROOT_W-1:0]      o_root
);

    logic [RAD_W-1:0]  r_rad  [ISQRT_STEPS-1];
    logic [REM_W-1:0]  r_rem  [ISQRT_STEPS-1];
    logic [ROOT_W-1:0] r_root [ISQRT_STEPS];

    logic [RAD_W-1:0]  c_rad_in  [ISQRT_STEPS];
    logic [REM_W-1:0]  c_rem_in  [ISQRT_STEPS];
    logic [ROOT_W-1:0] c_root_in [ISQRT_STEPS];
    logic [REM_W-1:0]  c_cur     [ISQRT_STEPS];
    logic [REM_W-1:0]  c_trial   [ISQRT_STEPS];
    logic [REM_W-1:0]  n_rem     [ISQRT_STEPS];
    logic [ROOT_W-1:0] n_root    [ISQRT_STEPS];

    always_comb begin
        c_rad_in[0]  = i_rad;
        c_rem_in[0]  = '0;
        c_root_in[0] = '0;
        for (int j = 1; j < ISQRT_STEPS; j++) begin
            c_rad_in[j]  = r_rad[j-1];
            c_rem_in[j]  = r_rem[j-1];
            c_root_in[j] = r_root[j-1];
        end
        for (int j = 0; j < ISQRT_STEPS; j++) begin
            c_cur[j]   = {c_rem_in[j][REM_W-3:0], c_rad_in[j][RAD_W-1:RAD_W-2]};
            c_trial[j] = {{(REM_W-ROOT_W-2){1'b0}}, c_root_in[j], 2'b01};
            if (c_cur[j] >= c_trial[j]) begin
                n_rem[j]  = c_cur[j] - c_trial[j];
                n_root[j] = {c_root_in[j][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[j]  = c_cur[j];
                n_root[j] = {c_root_in[j][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < ISQRT_STEPS - 1; j++) begin
            if (i_en[j]) begin
                r_rad[j] <= {c_rad_in[j][RAD_W-3:0], 2'b00};
                r_rem[j] <= n_rem[j];
            end
        end
        for (int j = 0; j < ISQRT_STEPS; j++) begin
            if (i_en[j]) begin
                r_root[j] <= n_root[j];
            end
        end
    end

    assign o_root = r_root[ISQRT_STEPS-1];

endmodule

[src/coa_acos.sv]
// pipelined arccosine of a clamped Q30 ratio: horner polynomial times sqrt(1-x)
// depends on coa_pkg and coa_isqrt
`timescale 1ns / 1ps

module coa_acos import coa_pkg::*; (
    input  logic                   i_clk,
    input  logic [ACOS_STAGES-1:0] i_en,
    input  logic [X_W-1:0]         i_x,
    input  logic                   i_neg,
    output logic [ACOS_W-1:0]      o_acos
);

    localparam int NSTEP = POLY_TERMS - 1;

    logic [PROD_W-1:0]      r_hprod [NSTEP];
    logic                   r_hneg  [NSTEP];
    logic signed [HP_W-1:0] r_hp    [NSTEP];
    logic [X_W-1:0]         r_hx    [HORNER_STAGES-2];
    logic [PD_W-1:0]        r_pd    [PD_DELAY];
    logic                   r_neg   [ACOS_STAGES-1];
    logic [RAD_W-1:0]       r_rad;
    logic [PROD_W-1:0]      r_ap;
    logic [ACOS_W-1:0]      r_acos;

    logic signed [HP_W-1:0] c_p_in [NSTEP];
    logic [X_W-1:0]         c_x_in [NSTEP];
    logic [HP_W-1:0]        c_pmag [NSTEP];
    logic [HP_W-1:0]        c_m    [NSTEP];
    logic signed [HP_W-1:0] n_hp   [NSTEP];
    logic [ROOT_W-1:0]      root;
    logic [X_W-1:0]         one_minus_x;

    always_comb begin
        c_p_in[0] = acos_coef(3'(NSTEP));
        c_x_in[0] = i_x;
        for (int i = 1; i < NSTEP; i++) begin
            c_p_in[i] = r_hp[i-1];
            c_x_in[i] = r_hx[2*i-1];
        end
        for (int i = 0; i < NSTEP; i++) begin
            c_pmag[i] = c_p_in[i][HP_W-1] ? HP_W'(-c_p_in[i]) : HP_W'(c_p_in[i]);
            c_m[i]    = r_hprod[i][PROD_W-1:Q_BITS];
            n_hp[i]   = (r_hneg[i] ? -$signed(c_m[i]) : $signed(c_m[i]))
                        + acos_coef(3'(NSTEP - 1 - i));
        end
        one_minus_x = Q30_ONE - i_x;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NSTEP; i++) begin
            if (i_en[2*i]) begin
                r_hprod[i] <= {{(PROD_W-HP_W){1'b0}}, c_pmag[i]}
                              * {{(PROD_W-X_W){1'b0}}, c_x_in[i]};
                r_hneg[i]  <= c_p_in[i][HP_W-1];
            end
            if (i_en[2*i+1]) begin
                r_hp[i] <= n_hp[i];
            end
        end
        for (int i = 0; i < NSTEP - 1; i++) begin
            if (i_en[2*i]) begin
                r_hx[2*i] <= c_x_in[i];
            end
            if (i_en[2*i+1]) begin
                r_hx[2*i+1] <= r_hx[2*i];
            end
        end
        if (i_en[HORNER_STAGES]) begin
            r_pd[0] <= r_hp[NSTEP-1][HP_W-1] ? '0 : r_hp[NSTEP-1][PD_W-1:0];
        end
        for (int k = 1; k < PD_DELAY; k++) begin
            if (i_en[HORNER_STAGES+k]) begin
                r_pd[k] <= r_pd[k-1];
            end
        end
        if (i_en[0]) begin
            r_rad    <= {1'b0, one_minus_x, {Q_BITS{1'b0}}};
            r_neg[0] <= i_neg;
        end
        for (int k = 1; k < ACOS_STAGES - 1; k++) begin
            if (i_en[k]) begin
                r_neg[k] <= r_neg[k-1];
            end
        end
        if (i_en[ACOS_STAGES-2]) begin
            r_ap <= {{(PROD_W-PD_W){1'b0}}, r_pd[PD_DELAY-1]}
                    * {{(PROD_W-ROOT_W){1'b0}}, root};
        end
        if (i_en[ACOS_STAGES-1]) begin
            r_acos <= r_neg[ACOS_STAGES-2] ? PI_Q30 - r_ap[Q_BITS+ACOS_W-1:Q_BITS]
                                           : r_ap[Q_BITS+ACOS_W-1:Q_BITS];
        end
    end

    coa_isqrt u_root (
        .i_clk  (i_clk),
        .i_en   (i_en[ISQRT_STEPS:1]),
        .i_rad  (r_rad),
        .o_root (root)
    );

    assign o_acos = r_acos;

endmodule

[src/circle_overlap_area_top.sv]
// channel | direction | handshake                 | payload
// request | in        | i_in_valid / o_in_ready   | i_radius_a, i_radius_b, i_centre_distance
// result  | out       | o_out_valid / i_out_ready | o_shared_area, o_overlap_case
//
// one request per cycle sustained while i_out_ready keeps results leaving the output
// each request runs through the 31-stage ratio divider followed by the 34-stage acos unit
// every stage holds a valid bit and loads whenever it is empty or the stage after it moves
// so bubbles close up and requests are taken while a result waits at the output
// synchronous active-low reset clears all valid bits; datapath registers are not reset
// depends on coa_pkg, coa_div, coa_isqrt, coa_acos and the assertion macro header
`timescale 1ns / 1ps

module circle_overlap_area_top import coa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [COORD_W-1:0] i_radius_a,
    input  logic [COORD_W-1:0] i_radius_b,
    input  logic [COORD_W-1:0] i_centre_distance,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [AREA_W-1:0]  o_shared_area,
    output logic [1:0]         o_overlap_case
);

`include "circle_overlap_area_top_assert.svh"

    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] stage_en;

    // stage 0
    logic [COORD_W-1:0] r_a, r_b, r_d, r_diff, r_small;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   n_sum;
    logic [COORD_W-1:0] n_diff, n_small;
    t_case              n_kind;
    // stage 1
    logic [SQ_W-1:0] r_dd, r_ss, r_f2, r_da, r_db;
    logic [PQ_W-1:0] r_s2;
    // stage 2
    logic [NUM_W-1:0]  r_num1, r_num2;
    logic [DIV_W-1:0]  r_den1p, r_den2p;
    logic [PQ_W-1:0]   r_p, r_q;
    logic [PROD_W-1:0] r_a1p;
    // stage 3
    logic [DIV_W-1:0] r_mag1, r_mag2, r_den1, r_den2;
    logic             r_clamp1, r_clamp2;
    logic [NUM_W-1:0] neg_num1, neg_num2;
    // tail
    logic [PROD_W-1:0] r_t1p, r_t2p;
    logic [SUMT_W-1:0] r_s, r_lens;
    logic [AREA_W-1:0] r_area_out;
    t_case             r_case_out;

    t_case             r_kind  [ST_IN:ST_SUB];
    logic [AREA_W-1:0] r_area1 [ST_CLAMP:ST_SUB];
    logic [SQ_W-1:0]   r_aa    [ST_MUL:ST_ACOS_END];
    logic [SQ_W-1:0]   r_bb    [ST_MUL:ST_ACOS_END];
    logic              r_neg1  [ST_CLAMP:ST_X];
    logic              r_neg2  [ST_CLAMP:ST_X];
    logic [H_W-1:0]    r_h     [ST_X:ST_SUM];

    logic [X_W-1:0]         x1, x2;
    logic [ROOT_W-1:0]      root_p, root_q;
    logic [ACOS_W-1:0]      acos1, acos2;
    logic [2*ROOT_W-1:0]    h_prod;

    always_comb begin
        stage_en[ST_OUT] = !r_v[ST_OUT] || i_out_ready;
        for (int k = ST_OUT - 1; k >= 0; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // classification at capture
    always_comb begin
        n_sum   = {1'b0, i_radius_a} + {1'b0, i_radius_b};
        n_diff  = (i_radius_a > i_radius_b) ? i_radius_a - i_radius_b
                                            : i_radius_b - i_radius_a;
        n_small = (i_radius_a < i_radius_b) ? i_radius_a : i_radius_b;
        if ({1'b0, i_centre_distance} >= n_sum) begin
            n_kind = CASE_DISJOINT;
        end else if (i_centre_distance <= n_diff) begin
            n_kind = CASE_INSIDE;
        end else begin
            n_kind = CASE_LENS;
        end
    end

    assign neg_num1 = -r_num1;
    assign neg_num2 = -r_num2;
    assign h_prod   = {{ROOT_W{1'b0}}, root_p} * {{ROOT_W{1'b0}}, root_q};

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_IN]) begin
            r_a           <= i_radius_a;
            r_b           <= i_radius_b;
            r_d           <= i_centre_distance;
            r_sum         <= n_sum;
            r_diff        <= n_diff;
            r_small       <= n_small;
            r_kind[ST_IN] <= n_kind;
        end
        if (stage_en[ST_MUL]) begin
            r_aa[ST_MUL] <= {{COORD_W{1'b0}}, r_a} * {{COORD_W{1'b0}}, r_a};
            r_bb[ST_MUL] <= {{COORD_W{1'b0}}, r_b} * {{COORD_W{1'b0}}, r_b};
            r_dd         <= {{COORD_W{1'b0}}, r_d} * {{COORD_W{1'b0}}, r_d};
            r_ss         <= {{COORD_W{1'b0}}, r_small} * {{COORD_W{1'b0}}, r_small};
            r_f2         <= {{COORD_W{1'b0}}, r_diff} * {{COORD_W{1'b0}}, r_diff};
            r_s2         <= {{SUM_W{1'b0}}, r_sum} * {{SUM_W{1'b0}}, r_sum};
            r_da         <= {{COORD_W{1'b0}}, r_d} * {{COORD_W{1'b0}}, r_a};
            r_db         <= {{COORD_W{1'b0}}, r_d} * {{COORD_W{1'b0}}, r_b};
        end
        if (stage_en[ST_PREP]) begin
            r_num1  <= {3'b000, r_dd} + {3'b000, r_aa[ST_MUL]} - {3'b000, r_bb[ST_MUL]};
            r_num2  <= {3'b000, r_dd} + {3'b000, r_bb[ST_MUL]} - {3'b000, r_aa[ST_MUL]};
            r_den1p <= {1'b0, r_da, 1'b0};
            r_den2p <= {1'b0, r_db, 1'b0};
            r_p     <= r_s2 - {2'b00, r_dd};
            r_q     <= {2'b00, r_dd} - {2'b00, r_f2};
            r_a1p   <= {{(PROD_W-SQ_W){1'b0}}, r_ss} * {{(PROD_W-ACOS_W){1'b0}}, PI_Q30};
        end
        if (stage_en[ST_CLAMP]) begin
            r_mag1   <= r_num1[NUM_W-1] ? neg_num1[DIV_W-1:0] : r_num1[DIV_W-1:0];
            r_mag2   <= r_num2[NUM_W-1] ? neg_num2[DIV_W-1:0] : r_num2[DIV_W-1:0];
            r_clamp1 <= (r_num1[NUM_W-1] ? neg_num1 : r_num1) >= {1'b0, r_den1p};
            r_clamp2 <= (r_num2[NUM_W-1] ? neg_num2 : r_num2) >= {1'b0, r_den2p};
            r_den1   <= r_den1p;
            r_den2   <= r_den2p;
            r_neg1[ST_CLAMP]  <= r_num1[NUM_W-1];
            r_neg2[ST_CLAMP]  <= r_num2[NUM_W-1];
            r_area1[ST_CLAMP] <= round_sat({1'b0, r_a1p[PROD_W-1:Q_BITS]});
        end
        for (int k = ST_IN + 1; k <= ST_SUB; k++) begin
            if (stage_en[k]) begin
                r_kind[k] <= r_kind[k-1];
            end
        end
        for (int k = ST_CLAMP + 1; k <= ST_SUB; k++) begin
            if (stage_en[k]) begin
                r_area1[k] <= r_area1[k-1];
            end
        end
        for (int k = ST_MUL + 1; k <= ST_ACOS_END; k++) begin
            if (stage_en[k]) begin
                r_aa[k] <= r_aa[k-1];
                r_bb[k] <= r_bb[k-1];
            end
        end
        for (int k = ST_CLAMP + 1; k <= ST_X; k++) begin
            if (stage_en[k]) begin
                r_neg1[k] <= r_neg1[k-1];
                r_neg2[k] <= r_neg2[k-1];
            end
        end
        if (stage_en[ST_X]) begin
            r_h[ST_X] <= h_prod[2*ROOT_W-1:2*SQRT_PAD+1];
        end
        for (int k = ST_X + 1; k <= ST_SUM; k++) begin
            if (stage_en[k]) begin
                r_h[k] <= r_h[k-1];
            end
        end
        if (stage_en[ST_TERM]) begin
            r_t1p <= {{(PROD_W-SQ_W){1'b0}}, r_aa[ST_ACOS_END]}
                     * {{(PROD_W-ACOS_W){1'b0}}, acos1};
            r_t2p <= {{(PROD_W-SQ_W){1'b0}}, r_bb[ST_ACOS_END]}
                     * {{(PROD_W-ACOS_W){1'b0}}, acos2};
        end
        if (stage_en[ST_SUM]) begin
            r_s <= {1'b0, r_t1p[PROD_W-1:Q_BITS]} + {1'b0, r_t2p[PROD_W-1:Q_BITS]};
        end
        if (stage_en[ST_SUB]) begin
            r_lens <= (r_s > {{(SUMT_W-H_W){1'b0}}, r_h[ST_SUM]})
                      ? r_s - {{(SUMT_W-H_W){1'b0}}, r_h[ST_SUM]} : '0;
        end
        if (stage_en[ST_OUT]) begin
            r_case_out <= r_kind[ST_SUB];
            case (r_kind[ST_SUB])
                CASE_LENS:   r_area_out <= round_sat(r_lens);
                CASE_INSIDE: r_area_out <= r_area1[ST_SUB];
                default:     r_area_out <= '0;
            endcase
        end
    end

    coa_isqrt u_root_p (
        .i_clk  (i_clk),
        .i_en   (stage_en[ST_ROOT0+ISQRT_STEPS-1:ST_ROOT0]),
        .i_rad  ({r_p, {(2*SQRT_PAD){1'b0}}}),
        .o_root (root_p)
    );

    coa_isqrt u_root_q (
        .i_clk  (i_clk),
        .i_en   (stage_en[ST_ROOT0+ISQRT_STEPS-1:ST_ROOT0]),
        .i_rad  ({r_q, {(2*SQRT_PAD){1'b0}}}),
        .o_root (root_q)
    );

    coa_div u_div1 (
        .i_clk   (i_clk),
        .i_en    (stage_en[ST_X:ST_DIV0]),
        .i_mag   (r_mag1),
        .i_den   (r_den1),
        .i_clamp (r_clamp1),
        .o_x     (x1)
    );

    coa_div u_div2 (
        .i_clk   (i_clk),
        .i_en    (stage_en[ST_X:ST_DIV0]),
        .i_mag   (r_mag2),
        .i_den   (r_den2),
        .i_clamp (r_clamp2),
        .o_x     (x2)
    );

    coa_acos u_acos1 (
        .i_clk  (i_clk),
        .i_en   (stage_en[ST_ACOS_END:ST_ACOS0]),
        .i_x    (x1),
        .i_neg  (r_neg1[ST_X]),
        .o_acos (acos1)
    );

    coa_acos u_acos2 (
        .i_clk  (i_clk),
        .i_en   (stage_en[ST_ACOS_END:ST_ACOS0]),
        .i_x    (x2),
        .i_neg  (r_neg2[ST_X]),
        .o_acos (acos2)
    );

    assign o_in_ready     = stage_en[0];
    assign o_out_valid    = r_v[ST_OUT];
    assign o_shared_area  = r_area_out;
    assign o_overlap_case = r_case_out;

    // disjoint circles never report area
    `COA_ASSERT_IMPL(a_disjoint_zero, o_out_valid && (r_case_out == CASE_DISJOINT), r_area_out == '0)
    // an empty output register means the whole pipe can move
    `COA_ASSERT_IMPL(a_empty_out_ready, !r_v[ST_OUT], o_in_ready)
    // a blocked first stage keeps its request
    `COA_ASSERT_NEXT(a_stage0_held, r_v[ST_IN] && !stage_en[ST_MUL], r_v[ST_IN])

endmodule

[test/tb_circle_overlap_area_top.sv]
// self-checking testbench for circle_overlap_area_top: directed and random geometry requests
// depends on coa_pkg and the circle_overlap_area_top rtl
`timescale 1ns / 1ps

module tb_circle_overlap_area_top;
    import coa_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] ra;
        logic [COORD_W-1:0] rb;
        logic [COORD_W-1:0] ctr_dist;
    } t_circles;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        t_case             kind;
    } t_overlap;

    localparam longint ACOS_TAYLOR [8] = '{1686629690, -230423709, 95540460, -53874249,
                                           33169905, -18348235, 7161955, -1355589};
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] PI_Q30_L = 64'd3373259426;
    localparam logic [63:0] AREA_TOP = (64'd1 << AREA_W) - 1;
    localparam int TIMEOUT_CYCLES = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [COORD_W-1:0] i_radius_a = '0;
    logic [COORD_W-1:0] i_radius_b = '0;
    logic [COORD_W-1:0] i_centre_distance = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [AREA_W-1:0] o_shared_area;
    logic [1:0] o_overlap_case;

    t_circles pending_q[$];
    t_overlap area_q[$];
    int n_sent = 0;
    int n_recv = 0;
    int n_errors = 0;
    int cycle_cnt = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    bit req_taken = 1'b0;
    bit res_taken = 1'b0;
    bit stim_done = 1'b0;

    circle_overlap_area_top dut (.*);

    always #10 i_clk = ~i_clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bt;
        root = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= root + bt) begin
                v -= root + bt;
                root = (root >> 1) + bt;
            end else begin
                root >>= 1;
            end
            bt >>= 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] arc_cos_mag(input logic [63:0] x);
        longint p;
        logic [63:0] m;
        logic [127:0] prod;
        bit neg;
        p = ACOS_TAYLOR[7];
        for (int i = 6; i >= 0; i--) begin
            neg = p < 0;
            m = neg ? -p : p;
            m = (m * x) >> 30;
            p = (neg ? -longint'(m) : longint'(m)) + ACOS_TAYLOR[i];
        end
        if (p < 0) p = 0;
        prod = 128'(p) * 128'(int_sqrt((ONE_Q30 - x) << 30));
        return 64'(prod >> 30);
    endfunction

    function automatic logic [63:0] arc_cos_ratio(input longint num, input logic [63:0] den);
        logic [63:0] mag;
        logic [63:0] x;
        logic [63:0] r;
        mag = num < 0 ? -num : num;
        if (den == 0 || mag >= den) x = ONE_Q30;
        else x = (mag << 30) / den;
        r = arc_cos_mag(x);
        return num < 0 ? PI_Q30_L - r : r;
    endfunction

    function automatic logic [AREA_W-1:0] round_area(input logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return r > AREA_TOP ? AREA_TOP[AREA_W-1:0] : r[AREA_W-1:0];
    endfunction

    function automatic t_overlap predict_overlap(input t_circles c);
        logic [63:0] a, b, d, sum, diff, small_r, aa, bb, dd, t1, t2, p, q, h, s;
        longint num1, num2;
        t_overlap res;
        a = c.ra;
        b = c.rb;
        d = c.ctr_dist;
        sum = a + b;
        diff = a > b ? a - b : b - a;
        small_r = a < b ? a : b;
        if (d >= sum) begin
            res.area = '0;
            res.kind = CASE_DISJOINT;
        end else if (d <= diff) begin
            res.area = round_area(64'((128'(small_r * small_r) * PI_Q30_L) >> 30));
            res.kind = CASE_INSIDE;
        end else begin
            aa = a * a;
            bb = b * b;
            dd = d * d;
            num1 = longint'(dd + aa) - longint'(bb);
            num2 = longint'(dd + bb) - longint'(aa);
            t1 = 64'((128'(aa) * arc_cos_ratio(num1, 2 * d * a)) >> 30);
            t2 = 64'((128'(bb) * arc_cos_ratio(num2, 2 * d * b)) >> 30);
            p = sum * sum - dd;
            q = dd - diff * diff;
            h = 64'((128'(int_sqrt(p << (2 * SQRT_PAD))) * int_sqrt(q << (2 * SQRT_PAD)))
                    >> (2 * SQRT_PAD + 1));
            s = t1 + t2;
            res.area = round_area(s > h ? s - h : 0);
            res.kind = CASE_LENS;
        end
        return res;
    endfunction

    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !req_taken) begin
            i_in_valid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            i_in_valid <= 1'b0;
        end else if (n_sent == 800 && area_q.size() != 0) begin
            i_in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
            {i_radius_a, i_radius_b, i_centre_distance} <= pending_q.pop_front();
            i_in_valid <= 1'b1;
            send_gap <= draw_gap();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // result ready with random stalls and one long hold-off
    always @(negedge i_clk) begin
        int stall_draw;
        if (!hold_done && n_recv == 400) begin
            hold_done <= 1'b1;
            hold_cnt <= 300;
            i_out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (res_taken) begin
            stall_draw = draw_gap();
            recv_stall <= (stall_draw > 0) ? stall_draw - 1 : 0;
            i_out_ready <= (stall_draw == 0);
        end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_overlap want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > TIMEOUT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
        req_taken <= i_in_valid && o_in_ready;
        res_taken <= o_out_valid && i_out_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            area_q.push_back(predict_overlap({i_radius_a, i_radius_b, i_centre_distance}));
            n_sent <= n_sent + 1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_recv <= n_recv + 1;
            if (area_q.size() == 0) begin
                n_errors <= n_errors + 1;
                if (n_errors < 10) $display("unexpected result area=%0d case=%0d",
                                            o_shared_area, o_overlap_case);
            end else begin
                want = area_q.pop_front();
                if (want.area !== o_shared_area || want.kind !== o_overlap_case) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < 10)
                        $display("mismatch: exp area=%0d case=%0d got area=%0d case=%0d",
                                 want.area, want.kind, o_shared_area, o_overlap_case);
                end
            end
        end
    end

    task automatic add_req(input int a, input int b, input int d);
        pending_q.push_back({16'(a), 16'(b), 16'(d)});
    endtask

    initial begin
        int a, b, d, lo, hi, w;
        add_req(0, 0, 0);
        add_req(65535, 65535, 65535);
        add_req(65535, 65535, 0);
        add_req(0, 65535, 100);
        add_req(256, 256, 512);
        add_req(256, 256, 600);
        add_req(512, 256, 256);
        add_req(512, 256, 100);
        add_req(300, 300, 0);
        add_req(256, 256, 256);
        add_req(1000, 900, 50);
        add_req(1, 1, 1);
        add_req(2, 3, 4);
        add_req(65535, 65534, 2);
        add_req(65535, 65535, 65534);
        add_req(40000, 30000, 20000);
        add_req(100, 65535, 65500);
        add_req(3, 1, 3);
        for (int i = 0; i < 1350; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                add_req($urandom, $urandom, $urandom);
            end else begin
                w = $urandom_range(1, 16);
                a = $urandom & ((1 << w) - 1);
                b = $urandom & ((1 << $urandom_range(1, 16)) - 1);
                lo = (a > b ? a - b : b - a) + 1;
                hi = a + b - 1;
                if (hi > 65535) hi = 65535;
                d = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 65535);
                add_req(a, b, d);
            end
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_q.size() == 0 && !i_in_valid);
        wait (area_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0 && area_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/coa_pkg.sv
src/coa_div.sv
src/coa_isqrt.sv
src/coa_acos.sv
src/circle_overlap_area_top.sv
test/tb_circle_overlap_area_top.sv
